/* rtl/tdf_pkg.sv */
// Package for the triangle dedup filter: sizes, codes, item types and helpers.
package tdf_pkg;

    // Table and index sizing
    localparam int TABLE_DEPTH = 4096;
    localparam int INDEX_BITS  = 16;
    localparam int FIELD_W     = 16;
    localparam int IDX_W       = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W       = 16;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Verdict codes
    typedef enum logic [1:0] {
        ST_KEPT  = 2'd0,
        ST_DEGEN = 2'd1,
        ST_DUP   = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Three corners as stored in the table
    typedef struct packed {
        logic [IDX_W-1:0] v0;
        logic [IDX_W-1:0] v1;
        logic [IDX_W-1:0] v2;
    } t_corners;

    // Classified word handed from front to back
    typedef struct packed {
        t_corners corners;
        logic     last;
        logic     degen;
    } t_job;

    // True when the entry equals the triangle or one of its cyclic rotations
    function automatic logic is_rotation(t_corners e, t_corners t);
        return ((e.v0 == t.v0) && (e.v1 == t.v1) && (e.v2 == t.v2)) ||
               ((e.v0 == t.v1) && (e.v1 == t.v2) && (e.v2 == t.v0)) ||
               ((e.v0 == t.v2) && (e.v1 == t.v0) && (e.v2 == t.v1));
    endfunction

    // Saturating increment of a running count
    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // Mask corners to the index width and flag repeated indices
    function automatic t_job make_job(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                                      logic [FIELD_W-1:0] c, logic last);
        t_job j;
        j.corners.v0 = IDX_W'(a);
        j.corners.v1 = IDX_W'(b);
        j.corners.v2 = IDX_W'(c);
        j.last       = last;
        j.degen      = (j.corners.v0 == j.corners.v1) ||
                       (j.corners.v1 == j.corners.v2) ||
                       (j.corners.v2 == j.corners.v0);
        return j;
    endfunction

endpackage

/* rtl/tdf_if.sv */
// Channel interfaces for triangle words in and verdict words out.
interface tdf_tri_if;
    logic                         valid;
    logic                         ready;
    logic [tdf_pkg::FIELD_W-1:0]  corner_a;
    logic [tdf_pkg::FIELD_W-1:0]  corner_b;
    logic [tdf_pkg::FIELD_W-1:0]  corner_c;
    logic                         end_of_mesh;

    modport source (output valid, corner_a, corner_b, corner_c, end_of_mesh, input ready);
    modport sink   (input valid, corner_a, corner_b, corner_c, end_of_mesh, output ready);
endinterface

interface tdf_verdict_if;
    logic                         valid;
    logic                         ready;
    logic                         keep;
    tdf_pkg::t_status             status;
    logic [tdf_pkg::FIELD_W-1:0]  out_a;
    logic [tdf_pkg::FIELD_W-1:0]  out_b;
    logic [tdf_pkg::FIELD_W-1:0]  out_c;
    logic [tdf_pkg::CNT_W-1:0]    kept_total;
    logic [tdf_pkg::CNT_W-1:0]    removed_total;
    logic                         mesh_done;

    modport source (output valid, keep, status, out_a, out_b, out_c, kept_total,
                    removed_total, mesh_done, input ready);
    modport sink   (input valid, keep, status, out_a, out_b, out_c, kept_total,
                    removed_total, mesh_done, output ready);
endinterface

/* rtl/tdf_front.sv */
// Front end: accept triangle words, classify them and queue them for the back end.
module tdf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tdf_tri_if.sink           i_tri,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output tdf_pkg::t_job     o_job
);

    tdf_pkg::t_job                   r_q [tdf_pkg::QUEUE_DEPTH];
    logic [tdf_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [tdf_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [tdf_pkg::QCNT_W-1:0]      r_count;
    logic                            push;
    logic                            pop;

    // Handshake on both sides of the queue
    assign i_tri.ready = (r_count != tdf_pkg::QCNT_W'(tdf_pkg::QUEUE_DEPTH));
    assign push        = i_tri.valid && i_tri.ready;
    assign o_job_valid = (r_count != '0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rd_ptr];

    // Store the classified word
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= tdf_pkg::make_job(i_tri.corner_a, i_tri.corner_b,
                                               i_tri.corner_c, i_tri.end_of_mesh);
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == tdf_pkg::QPTR_W'(tdf_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == tdf_pkg::QPTR_W'(tdf_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/tdf_back.sv */
// Back end: scan the kept-triangle table, form the verdict and keep the counts.
module tdf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  tdf_pkg::t_job     i_job,
    tdf_verdict_if.source     o_verdict
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    tdf_pkg::t_job                   r_job;
    logic [tdf_pkg::FILL_W-1:0]      r_fill;
    logic [tdf_pkg::FILL_W-1:0]      r_issue;
    logic                            r_chk;
    logic                            r_dup;
    logic [tdf_pkg::CNT_W-1:0]       r_kept;
    logic [tdf_pkg::CNT_W-1:0]       r_removed;
    tdf_pkg::t_corners               r_mem [tdf_pkg::TABLE_DEPTH];
    tdf_pkg::t_corners               r_rd_data;

    logic                            r_out_valid;
    logic                            r_out_keep;
    tdf_pkg::t_status                r_out_status;
    logic [tdf_pkg::FIELD_W-1:0]     r_out_a;
    logic [tdf_pkg::FIELD_W-1:0]     r_out_b;
    logic [tdf_pkg::FIELD_W-1:0]     r_out_c;
    logic [tdf_pkg::CNT_W-1:0]       r_out_kept;
    logic [tdf_pkg::CNT_W-1:0]       r_out_removed;
    logic                            r_out_done;

    logic                            take;
    logic                            hit;
    logic                            scan_done;
    logic                            rd_en;
    logic                            full;
    logic                            keep_v;
    logic                            wr_en;
    tdf_pkg::t_status                status_v;
    logic [tdf_pkg::CNT_W-1:0]       kept_nxt;
    logic [tdf_pkg::CNT_W-1:0]       removed_nxt;

    // Take a word only when idle and the verdict register is empty
    assign o_job_ready = (r_state == S_IDLE) && !r_out_valid;
    assign take        = i_job_valid && o_job_ready;

    // Scan: one table read per cycle, compare the registered read data
    assign hit       = (r_state == S_SCAN) && r_chk &&
                       tdf_pkg::is_rotation(r_rd_data, r_job.corners);
    assign scan_done = (r_issue == r_fill) && !r_chk;
    assign rd_en     = (r_state == S_SCAN) && !hit && (r_issue != r_fill);

    // Verdict
    assign full   = (r_fill == tdf_pkg::FILL_W'(tdf_pkg::TABLE_DEPTH));
    assign keep_v = !r_job.degen && !r_dup;
    assign wr_en  = (r_state == S_FIN) && keep_v && !full;

    always_comb begin
        if (r_job.degen) begin
            status_v = tdf_pkg::ST_DEGEN;
        end else if (r_dup) begin
            status_v = tdf_pkg::ST_DUP;
        end else if (full) begin
            status_v = tdf_pkg::ST_FULL;
        end else begin
            status_v = tdf_pkg::ST_KEPT;
        end
    end

    assign kept_nxt    = keep_v ? tdf_pkg::sat_inc(r_kept) : r_kept;
    assign removed_nxt = keep_v ? r_removed : tdf_pkg::sat_inc(r_removed);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_state = i_job.degen ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit || scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Table memory: write on store, registered read during scan
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fill[tdf_pkg::ADDR_W-1:0]] <= r_job.corners;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_issue[tdf_pkg::ADDR_W-1:0]];
        end
    end

    // Hold the current word and the verdict payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job <= i_job;
        end
        if (r_state == S_FIN) begin
            r_out_keep    <= keep_v;
            r_out_status  <= status_v;
            r_out_a       <= tdf_pkg::FIELD_W'(r_job.corners.v0);
            r_out_b       <= tdf_pkg::FIELD_W'(r_job.corners.v1);
            r_out_c       <= tdf_pkg::FIELD_W'(r_job.corners.v2);
            r_out_kept    <= kept_nxt;
            r_out_removed <= removed_nxt;
            r_out_done    <= r_job.last;
        end
    end

    // Control state, fill level and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_issue     <= '0;
            r_chk       <= 1'b0;
            r_dup       <= 1'b0;
            r_kept      <= '0;
            r_removed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take) begin
                r_issue <= '0;
                r_chk   <= 1'b0;
                r_dup   <= 1'b0;
            end
            if (r_state == S_SCAN) begin
                r_chk <= rd_en;
                if (rd_en) begin
                    r_issue <= r_issue + 1'b1;
                end
                if (hit) begin
                    r_dup <= 1'b1;
                end
            end
            if (r_state == S_FIN) begin
                if (r_job.last) begin
                    r_fill    <= '0;
                    r_kept    <= '0;
                    r_removed <= '0;
                end else begin
                    r_fill    <= r_fill + tdf_pkg::FILL_W'(wr_en);
                    r_kept    <= kept_nxt;
                    r_removed <= removed_nxt;
                end
            end
            // Drop the verdict once taken, load a new one at the end of a word
            if (r_state == S_FIN) begin
                r_out_valid <= 1'b1;
            end else if (o_verdict.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_verdict.valid         = r_out_valid;
    assign o_verdict.keep          = r_out_keep;
    assign o_verdict.status        = r_out_status;
    assign o_verdict.out_a         = r_out_a;
    assign o_verdict.out_b         = r_out_b;
    assign o_verdict.out_c         = r_out_c;
    assign o_verdict.kept_total    = r_out_kept;
    assign o_verdict.removed_total = r_out_removed;
    assign o_verdict.mesh_done     = r_out_done;

endmodule

/* rtl/triangle_dedup_filter.sv */
// A degenerate triangle goes from S_IDLE straight to S_FIN, where its verdict is loaded;
// another first passes S_SCAN, which checks up to fill table entries until a hit, where fill is
// the number of triangles stored for the current mesh (at most 4096), read one per cycle.
// The back end takes a new triangle only in S_IDLE once its verdict has been taken, so it
// cannot start one before the last is done; a two-word queue fills during a scan.
// Reset clears counts, fill level, queue and handshakes at once; the table needs no clearing.
module triangle_dedup_filter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tdf_tri_if.sink       i_tri,
    tdf_verdict_if.source o_verdict
);

    logic           job_valid;
    logic           job_ready;
    tdf_pkg::t_job  job;

    // Classify and queue incoming triangles
    tdf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tri       (i_tri),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    // Scan the table and issue verdicts
    tdf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_verdict   (o_verdict)
    );

endmodule
